@@ rtl/core/aadt_pkg.sv @@
// Shared types and constants for the adaptive delayed-ACK timer table.
// No dependencies; used by aadt_ctrl, aadt_dp and the top level.
package aadt_pkg;

    localparam int TYPE_W     = 4;
    localparam int SID_W      = 5;
    localparam int PAY_W      = 48;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int CAP_COUNT  = 7;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_64  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_32  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_16  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_8   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_4   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_2   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_1   = 3'd7;

    localparam logic [TYPE_W-1:0] ACK_TYPE_RESET = 4'd0;

    typedef logic [CFG_DATA_W-1:0] delay_cfg_t;
    typedef delay_cfg_t [CAP_COUNT-1:0] delay_cfg_array_t;

    localparam delay_cfg_array_t DELAY_RESET = '{
        12'd5, 12'd10, 12'd20, 12'd40, 12'd79, 12'd157, 12'd313
    };

    // Ack count codes
    localparam logic [CNT_W-1:0] CNT_IDLE  = 4'd0;
    localparam logic [CNT_W-1:0] CNT_FIRST = 4'd1;
    localparam logic [CNT_W-1:0] CNT_CAPS  = 4'd6;
    localparam logic [CNT_W-1:0] CNT_LAST  = 4'd7;
    localparam logic [CNT_W-1:0] CNT_DONE  = 4'd8;

    // Item command codes
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic clr_wr;   // write zero at the sweep pointer and advance it
        logic accept;   // take the input item and launch the table read
        logic exec;     // update the entry and load the result register
    } aadt_cmd_t;

    typedef struct packed {
        logic ptr_last; // sweep pointer sits on the last entry
        logic out_free; // result register can take a new item
    } aadt_sts_t;

endpackage

@@ rtl/core/aadt_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module aadt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/aadt_ctrl.sv @@
// Sequencer for the delayed-ACK timer table: clear pass, accept, execute.
// Depends on aadt_pkg.
module aadt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  aadt_pkg::aadt_sts_t sts,
    output aadt_pkg::aadt_cmd_t cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.ptr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.clr_wr = (state_reg == ST_CLEAR);
    assign cmd.accept = (state_reg == ST_IDLE) && s_valid;
    assign cmd.exec   = (state_reg == ST_EXEC) && sts.out_free;

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_EXEC))
        else $error("accepted item did not move to execute");

    a_exec_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> sts.out_free)
        else $error("execute issued while result register is occupied");

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !cmd.accept && !cmd.exec)
        else $error("item work overlapped the clear pass");

endmodule

@@ rtl/core/aadt_dp.sv @@
// Datapath for the delayed-ACK timer table: config registers, entry RAM,
// sweep pointer, entry update and result register. Depends on aadt_pkg, aadt_ram.
module aadt_dp #(
    parameter int SESSIONS   = 32,
    parameter int DELAY_BITS = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [aadt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aadt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_cmd,
    input  logic [aadt_pkg::TYPE_W-1:0]        s_event_type,
    input  logic [aadt_pkg::SID_W-1:0]         s_session_id,
    input  logic [aadt_pkg::PAY_W-1:0]         s_event_payload,
    input  logic                               s_tx_full,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_rx_sig,
    output logic                               m_tx_valid,
    output logic [aadt_pkg::TYPE_W-1:0]        m_tx_type,
    output logic [aadt_pkg::SID_W-1:0]         m_tx_session,
    output logic [aadt_pkg::PAY_W-1:0]         m_tx_payload,
    input  aadt_pkg::aadt_cmd_t                cmd,
    output aadt_pkg::aadt_sts_t                sts
);

    localparam int AW     = $clog2(SESSIONS);
    localparam int WORD_W = DELAY_BITS + aadt_pkg::CNT_W;
    localparam logic [AW-1:0] PTR_LAST = AW'(SESSIONS - 1);
    localparam logic [DELAY_BITS-1:0] DELAY_ONE = DELAY_BITS'(1);

    // Configuration
    logic [aadt_pkg::TYPE_W-1:0] ack_code_reg;
    aadt_pkg::delay_cfg_array_t  delay_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_code_reg  <= aadt_pkg::ACK_TYPE_RESET;
            delay_cfg_reg <= aadt_pkg::DELAY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                aadt_pkg::REG_ACK_TYPE: begin
                    ack_code_reg <= cfg_data[aadt_pkg::TYPE_W-1:0];
                end
                default: begin
                    delay_cfg_reg[3'(cfg_index - aadt_pkg::REG_DELAY_64)] <= cfg_data;
                end
            endcase
        end
    end

    // Sweep pointer, also the address counter of the clear pass
    logic [AW-1:0] ptr_reg;
    logic          ptr_adv;

    assign ptr_adv = cmd.clr_wr || (cmd.accept && (s_cmd == aadt_pkg::CMD_TICK));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (ptr_adv) begin
            ptr_reg <= (ptr_reg == PTR_LAST) ? '0 : AW'(ptr_reg + 1'b1);
        end
    end

    // Session id mapped onto the table address range
    logic [AW+aadt_pkg::SID_W-1:0] sid_ext;
    logic [AW-1:0]                 sid_addr;
    logic                          sid_in_table;

    assign sid_ext      = {{AW{1'b0}}, s_session_id};
    assign sid_addr     = sid_ext[AW-1:0];
    assign sid_in_table = (32'(s_session_id) < 32'(SESSIONS));

    // Latched item
    logic                        item_cmd_reg;
    logic [aadt_pkg::TYPE_W-1:0] item_type_reg;
    logic [aadt_pkg::SID_W-1:0]  item_sid_reg;
    logic [aadt_pkg::PAY_W-1:0]  item_pay_reg;
    logic                        item_full_reg;
    logic                        item_in_table_reg;
    logic [AW-1:0]               item_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_cmd_reg      <= s_cmd;
            item_type_reg     <= s_event_type;
            item_sid_reg      <= s_session_id;
            item_pay_reg      <= s_event_payload;
            item_full_reg     <= s_tx_full;
            item_in_table_reg <= sid_in_table;
            item_addr_reg     <= (s_cmd == aadt_pkg::CMD_TICK) ? ptr_reg : sid_addr;
        end
    end

    // Entry store: {delay, ack count}
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic [AW-1:0]     ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    assign ram_rd_addr = (s_cmd == aadt_pkg::CMD_TICK) ? ptr_reg : sid_addr;

    aadt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SESSIONS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Entry update
    logic [DELAY_BITS-1:0]          cur_delay;
    logic [aadt_pkg::CNT_W-1:0]     cur_cnt;
    logic [DELAY_BITS+11:0]         init_ext;
    logic [DELAY_BITS+11:0]         cap_ext;
    logic [DELAY_BITS-1:0]          init_delay;
    logic [DELAY_BITS-1:0]          cap_delay;
    logic [DELAY_BITS-1:0]          new_delay;
    logic [aadt_pkg::CNT_W-1:0]     new_cnt;
    logic                           upd_en;
    logic                           is_ack;
    logic                           r_rx;
    logic                           r_tx;
    logic [aadt_pkg::TYPE_W-1:0]    r_type;
    logic [aadt_pkg::SID_W-1:0]     r_sid;
    logic [aadt_pkg::PAY_W-1:0]     r_pay;
    logic [AW+aadt_pkg::SID_W-1:0]  tick_sid_ext;

    assign cur_delay    = ram_rd_data[WORD_W-1:aadt_pkg::CNT_W];
    assign cur_cnt      = ram_rd_data[aadt_pkg::CNT_W-1:0];
    assign init_ext     = {{DELAY_BITS{1'b0}}, delay_cfg_reg[0]};
    assign cap_ext      = {{DELAY_BITS{1'b0}}, delay_cfg_reg[cur_cnt[2:0]]};
    assign init_delay   = init_ext[DELAY_BITS-1:0];
    assign cap_delay    = cap_ext[DELAY_BITS-1:0];
    assign is_ack       = (item_type_reg == ack_code_reg);
    assign tick_sid_ext = {{aadt_pkg::SID_W{1'b0}}, item_addr_reg};

    always_comb begin
        new_delay = cur_delay;
        new_cnt   = cur_cnt;
        upd_en    = 1'b0;
        r_rx      = 1'b0;
        r_tx      = 1'b0;
        r_type    = '0;
        r_sid     = '0;
        r_pay     = '0;
        if (item_cmd_reg == aadt_pkg::CMD_EVENT) begin
            r_rx   = 1'b1;
            upd_en = item_in_table_reg;
            if (is_ack) begin
                if (cur_delay == '0) begin
                    new_delay = init_delay;
                    new_cnt   = aadt_pkg::CNT_FIRST;
                end else if (cur_cnt >= aadt_pkg::CNT_FIRST && cur_cnt <= aadt_pkg::CNT_CAPS) begin
                    if (cur_delay > cap_delay) begin
                        new_delay = cap_delay;
                    end
                    new_cnt = aadt_pkg::CNT_W'(cur_cnt + 1'b1);
                end else if (cur_cnt == aadt_pkg::CNT_LAST) begin
                    new_delay = DELAY_ONE;
                    new_cnt   = aadt_pkg::CNT_DONE;
                end
            end else begin
                // Non-ACK: clear the entry and forward regardless of back-pressure
                new_delay = '0;
                new_cnt   = aadt_pkg::CNT_IDLE;
                r_tx      = 1'b1;
                r_type    = item_type_reg;
                r_sid     = item_sid_reg;
                r_pay     = item_pay_reg;
            end
        end else begin
            if (cur_delay != '0 && !item_full_reg) begin
                upd_en    = 1'b1;
                new_delay = DELAY_BITS'(cur_delay - 1'b1);
                if (cur_delay == DELAY_ONE) begin
                    r_tx   = 1'b1;
                    r_type = ack_code_reg;
                    r_sid  = tick_sid_ext[aadt_pkg::SID_W-1:0];
                end
            end
        end
    end

    assign ram_wr_en   = cmd.clr_wr || (cmd.exec && upd_en);
    assign ram_wr_addr = cmd.clr_wr ? ptr_reg : item_addr_reg;
    assign ram_wr_data = cmd.clr_wr ? '0 : {new_delay, new_cnt};

    // Result register
    logic                        m_valid_reg;
    logic                        m_rx_reg;
    logic                        m_tx_reg;
    logic [aadt_pkg::TYPE_W-1:0] m_type_reg;
    logic [aadt_pkg::SID_W-1:0]  m_sid_reg;
    logic [aadt_pkg::PAY_W-1:0]  m_pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_rx_reg   <= r_rx;
            m_tx_reg   <= r_tx;
            m_type_reg <= r_type;
            m_sid_reg  <= r_sid;
            m_pay_reg  <= r_pay;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_rx_sig     = m_rx_reg;
    assign m_tx_valid   = m_tx_reg;
    assign m_tx_type    = m_type_reg;
    assign m_tx_session = m_sid_reg;
    assign m_tx_payload = m_pay_reg;

    assign sts.ptr_last = (ptr_reg == PTR_LAST);
    assign sts.out_free = !m_valid_reg || m_ready;

    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ptr_reg) < 32'(SESSIONS))
        else $error("sweep pointer out of range");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> ram_wr_data[aadt_pkg::CNT_W-1:0] <= aadt_pkg::CNT_DONE)
        else $error("ack count written above its final value");

    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_tx_valid) |->
            (m_tx_type == '0) && (m_tx_session == '0) && (m_tx_payload == '0))
        else $error("result fields not zero without a transmit");

endmodule

@@ rtl/core/adaptive_ack_delay_table_unit.sv @@
// Top level of the adaptive delayed-ACK timer table.
// Depends on aadt_pkg, aadt_ctrl, aadt_dp (which holds aadt_ram).
//
//  port group | direction | transfer condition
//  s_*        | in        | s_valid && s_ready
//  m_*        | out       | m_valid && m_ready
//  cfg_*      | in        | cfg_wr_en
//
// Each item first reads its table entry from the RAM's registered read port,
// then updates the entry and loads the result register.
// The result register lets the next item start while the last result waits.
// After reset a clear pass writes zero to every entry, with
// s_ready low. A stalled m_ready holds the item in its update cycle.
module adaptive_ack_delay_table_unit #(
    parameter int SESSIONS   = 32,
    parameter int DELAY_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [aadt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aadt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [aadt_pkg::TYPE_W-1:0]     s_event_type,
    input  logic [aadt_pkg::SID_W-1:0]      s_session_id,
    input  logic [aadt_pkg::PAY_W-1:0]      s_event_payload,
    input  logic                            s_tx_full,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_rx_sig,
    output logic                            m_tx_valid,
    output logic [aadt_pkg::TYPE_W-1:0]     m_tx_type,
    output logic [aadt_pkg::SID_W-1:0]      m_tx_session,
    output logic [aadt_pkg::PAY_W-1:0]      m_tx_payload
);

    aadt_pkg::aadt_cmd_t cmd;
    aadt_pkg::aadt_sts_t sts;

    aadt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aadt_dp #(
        .SESSIONS   (SESSIONS),
        .DELAY_BITS (DELAY_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_cmd           (s_cmd),
        .s_event_type    (s_event_type),
        .s_session_id    (s_session_id),
        .s_event_payload (s_event_payload),
        .s_tx_full       (s_tx_full),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rx_sig        (m_rx_sig),
        .m_tx_valid      (m_tx_valid),
        .m_tx_type       (m_tx_type),
        .m_tx_session    (m_tx_session),
        .m_tx_payload    (m_tx_payload),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

@@ tb/adaptive_ack_delay_table_unit_tb.sv @@
// Testbench for adaptive_ack_delay_table_unit: directed and random events and ticks,
// with results checked against a timer-table scoreboard. Uses aadt_pkg and the RTL
// under rtl/core.
module adaptive_ack_delay_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aadt_pkg::*;

    localparam int N_SESSIONS = 32;
    localparam int DELAY_W    = 12;

    typedef struct packed {
        logic              cmd;
        logic [TYPE_W-1:0] etype;
        logic [SID_W-1:0]  sid;
        logic [PAY_W-1:0]  payload;
        logic              tx_full;
    } timer_item_t;

    typedef struct packed {
        logic              rx_sig;
        logic              tx_valid;
        logic [TYPE_W-1:0] tx_type;
        logic [SID_W-1:0]  tx_session;
        logic [PAY_W-1:0]  tx_payload;
    } timer_resp_t;

    class ack_timer_scoreboard;
        logic [TYPE_W-1:0]  ack_code;
        logic [DELAY_W-1:0] delay_caps [CAP_COUNT];
        logic [DELAY_W-1:0] pending_delay [N_SESSIONS];
        logic [CNT_W-1:0]   ack_count [N_SESSIONS];
        logic [SID_W-1:0]   sweep_ptr;
        timer_resp_t        expected_responses [$];
        int                 errors;

        function new();
            ack_code   = ACK_TYPE_RESET;
            delay_caps = '{12'd313, 12'd157, 12'd79, 12'd40, 12'd20, 12'd10, 12'd5};
            foreach (pending_delay[k]) begin
                pending_delay[k] = '0;
                ack_count[k]     = CNT_IDLE;
            end
            sweep_ptr = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_ACK_TYPE) begin
                ack_code = value[TYPE_W-1:0];
            end else begin
                delay_caps[idx - REG_DELAY_64] = value[DELAY_W-1:0];
            end
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        // Arm a session on its first ACK, then tighten the delay per further ACK.
        function void register_ack(logic [SID_W-1:0] s);
            logic [DELAY_W-1:0] cap;
            if (pending_delay[s] == '0) begin
                pending_delay[s] = delay_caps[0];
                ack_count[s]     = CNT_FIRST;
            end else if (ack_count[s] >= CNT_FIRST && ack_count[s] <= CNT_CAPS) begin
                cap = delay_caps[ack_count[s][2:0]];
                if (pending_delay[s] > cap) begin
                    pending_delay[s] = cap;
                end
                ack_count[s] = ack_count[s] + 1'b1;
            end else if (ack_count[s] == CNT_LAST) begin
                pending_delay[s] = DELAY_W'(1);
                ack_count[s]     = CNT_DONE;
            end
        endfunction

        function timer_resp_t timer_table_step(timer_item_t it);
            timer_resp_t r;
            logic [SID_W-1:0] p;
            r = '0;
            if (it.cmd == CMD_EVENT) begin
                r.rx_sig = 1'b1;
                if (it.etype == ack_code) begin
                    register_ack(it.sid);
                end else begin
                    pending_delay[it.sid] = '0;
                    ack_count[it.sid]     = CNT_IDLE;
                    r.tx_valid   = 1'b1;
                    r.tx_type    = it.etype;
                    r.tx_session = it.sid;
                    r.tx_payload = it.payload;
                end
            end else begin
                p = sweep_ptr;
                if (pending_delay[p] != '0 && !it.tx_full) begin
                    if (pending_delay[p] == DELAY_W'(1)) begin
                        r.tx_valid   = 1'b1;
                        r.tx_type    = ack_code;
                        r.tx_session = p;
                    end
                    pending_delay[p] = pending_delay[p] - 1'b1;
                end
                // pointer is exactly as wide as the table, so it wraps by itself
                sweep_ptr = p + 1'b1;
            end
            return r;
        endfunction

        function void note_transfer(timer_item_t it);
            expected_responses.push_back(timer_table_step(it));
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 40) begin
                $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
            end
        endtask

        task check_response(timer_resp_t got);
            timer_resp_t want;
            if (expected_responses.size() == 0) begin
                report_mismatch("unexpected result", 64'(got), '0);
                return;
            end
            want = expected_responses.pop_front();
            if (got.rx_sig !== want.rx_sig)
                report_mismatch("rx_sig", 64'(got.rx_sig), 64'(want.rx_sig));
            if (got.tx_valid !== want.tx_valid)
                report_mismatch("tx_valid", 64'(got.tx_valid), 64'(want.tx_valid));
            if (got.tx_type !== want.tx_type)
                report_mismatch("tx_type", 64'(got.tx_type), 64'(want.tx_type));
            if (got.tx_session !== want.tx_session)
                report_mismatch("tx_session", 64'(got.tx_session), 64'(want.tx_session));
            if (got.tx_payload !== want.tx_payload)
                report_mismatch("tx_payload", 64'(got.tx_payload), 64'(want.tx_payload));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_cmd;
    logic [TYPE_W-1:0]     s_event_type;
    logic [SID_W-1:0]      s_session_id;
    logic [PAY_W-1:0]      s_event_payload;
    logic                  s_tx_full;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_rx_sig;
    logic                  m_tx_valid;
    logic [TYPE_W-1:0]     m_tx_type;
    logic [SID_W-1:0]      m_tx_session;
    logic [PAY_W-1:0]      m_tx_payload;

    ack_timer_scoreboard sb;
    bit                  calm = 1'b0;
    logic [SID_W-1:0]    focus [3];

    adaptive_ack_delay_table_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_event_type    (s_event_type),
        .s_session_id    (s_session_id),
        .s_event_payload (s_event_payload),
        .s_tx_full       (s_tx_full),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rx_sig        (m_rx_sig),
        .m_tx_valid      (m_tx_valid),
        .m_tx_type       (m_tx_type),
        .m_tx_session    (m_tx_session),
        .m_tx_payload    (m_tx_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2400000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: stall at random except during the calm phase.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready = calm || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_response({m_rx_sig, m_tx_valid, m_tx_type, m_tx_session, m_tx_payload});
        end
    end

    function automatic logic [PAY_W-1:0] random_payload();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[PAY_W-1:0];
    endfunction

    function automatic timer_item_t mk_item(logic cmd, logic [TYPE_W-1:0] etype,
                                            logic [SID_W-1:0] sid, logic [PAY_W-1:0] payload,
                                            logic tx_full);
        timer_item_t it;
        it.cmd     = cmd;
        it.etype   = etype;
        it.sid     = sid;
        it.payload = payload;
        it.tx_full = tx_full;
        return it;
    endfunction

    function automatic delay_cfg_array_t short_delays();
        delay_cfg_array_t d;
        d[0] = 12'($urandom_range(8, 1));
        for (int k = 1; k < CAP_COUNT; k++) begin
            d[k] = 12'(($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(6));
        end
        return d;
    endfunction

    // Entered and left at a falling edge; valid stays up until the next call decides.
    task automatic push_item(input timer_item_t it);
        while (!calm && $urandom_range(99) < 22) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_cmd           = it.cmd;
        s_event_type    = it.etype;
        s_session_id    = it.sid;
        s_event_payload = it.payload;
        s_tx_full       = it.tx_full;
        do @(posedge aclk); while (!s_ready);
        sb.note_transfer(it);
        @(negedge aclk);
    endtask

    task automatic push_random_item();
        timer_item_t it;
        int roll;
        roll       = $urandom_range(99);
        it.payload = random_payload();
        it.sid     = SID_W'($urandom_range(N_SESSIONS - 1));
        it.etype   = TYPE_W'($urandom_range(15));
        it.tx_full = 1'($urandom_range(1));
        if (roll < 45) begin
            it.cmd     = CMD_TICK;
            it.tx_full = ($urandom_range(99) < 15);
        end else if (roll < 82) begin
            // ACK bursts on a few sessions drive the counts all the way up
            it.cmd   = CMD_EVENT;
            it.etype = sb.ack_code;
            if ($urandom_range(9) != 0) begin
                it.sid = focus[$urandom_range(2)];
            end
        end else begin
            it.cmd = CMD_EVENT;
            if (it.etype == sb.ack_code) begin
                it.etype = it.etype + 1'b1;
            end
            if ($urandom_range(3) == 0) begin
                it.sid = focus[$urandom_range(2)];
            end
        end
        push_item(it);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic run_phase(input bit load, input logic [CFG_DATA_W-1:0] ack_word,
                             input delay_cfg_array_t d, input int n, input bit quiet,
                             input bit pause_midway);
        wait_drained();
        if (load) begin
            write_reg(REG_ACK_TYPE, ack_word);
            write_reg(REG_DELAY_64, d[0]);
            write_reg(REG_DELAY_32, d[1]);
            write_reg(REG_DELAY_16, d[2]);
            write_reg(REG_DELAY_8,  d[3]);
            write_reg(REG_DELAY_4,  d[4]);
            write_reg(REG_DELAY_2,  d[5]);
            write_reg(REG_DELAY_1,  d[6]);
        end
        calm = quiet;
        foreach (focus[k]) focus[k] = SID_W'($urandom_range(N_SESSIONS - 1));
        for (int k = 0; k < n; k++) begin
            if (pause_midway && k == n / 2) begin
                wait_drained();
            end
            push_random_item();
        end
        calm = 1'b0;
    endtask

    initial begin
        timer_item_t directed [$];
        sb              = new();
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_cmd           = CMD_EVENT;
        s_event_type    = '0;
        s_session_id    = '0;
        s_event_payload = '0;
        s_tx_full       = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // tick on an idle entry, pointer moves to 1
        directed.push_back(mk_item(CMD_TICK, 4'hF, 5'd31, '1, 1'b0));
        // walk session 1 through every count, then one ACK past the last
        repeat (9) directed.push_back(mk_item(CMD_EVENT, sb.ack_code, 5'd1, '1, 1'b0));
        // full output holds entry 1 at its final delay
        directed.push_back(mk_item(CMD_TICK, '0, '0, '0, 1'b1));
        repeat (9) directed.push_back(mk_item(CMD_EVENT, sb.ack_code, 5'd2, '0, 1'b1));
        // entry 2 expires and emits its ACK
        directed.push_back(mk_item(CMD_TICK, '0, '0, '0, 1'b0));
        // forwarding ignores back-pressure
        directed.push_back(mk_item(CMD_EVENT, 4'hF, 5'd31, '1, 1'b1));
        directed.push_back(mk_item(CMD_EVENT, 4'h1, 5'd1, '0, 1'b0));
        directed.push_back(mk_item(CMD_EVENT, sb.ack_code, 5'd31, '0, 1'b0));
        foreach (directed[k]) push_item(directed[k]);

        run_phase(1'b0, '0, '0, 160, 1'b0, 1'b0);
        run_phase(1'b1, 12'hA35,
                  {12'd1, 12'd1, 12'd1, 12'd1, 12'd2, 12'd2, 12'd3}, 200, 1'b1, 1'b0);
        run_phase(1'b1, 12'hFFF, '1, 180, 1'b0, 1'b0);
        run_phase(1'b1, 12'h000, '0, 120, 1'b0, 1'b0);
        run_phase(1'b1, 12'($urandom_range(4095)), short_delays(), 220, 1'b0, 1'b1);
        repeat (3) begin
            run_phase(1'b1, 12'($urandom_range(4095)), short_delays(), 220, 1'b0, 1'b0);
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
